### design/ffha_pkg.sv
// First-fit heap allocator package: request and result structs, descriptor layout,
// command codes, sequencer states and shared constants.
// No dependencies.
package ffha_pkg;

	localparam int DESCRIPTORS_DEF = 128;
	localparam logic [15:0] NIL = 16'hFFFF;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE  = 1'd1;

	// header word plus rounding up to a whole 16-byte unit
	localparam logic [5:0] NEED_ROUND = 6'd19;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] align;
		logic [19:0] size;
		logic        raw_mode;
		logic [31:0] address;
		logic [15:0] header_units;
	} in_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic        success;
		logic        header_write;
		logic [31:0] header_address;
		logic [15:0] header_value;
		logic [15:0] free_units;
		logic [15:0] low_water;
	} out_t;

	typedef struct packed {
		logic [31:0] start;
		logic [15:0] units;
		logic [15:0] next;
	} desc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_A_MUL,
		ST_A_NEED,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_A_UNLINK,
		ST_A_SPARE,
		ST_F_NX_RD,
		ST_F_NX_CHK,
		ST_F_NX_WR,
		ST_F_SP_RD,
		ST_F_SP_CHK,
		ST_F_PREV_WR,
		ST_DONE
	} state_t;

endpackage

### design/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/first_fit_heap_allocator.sv
// First-fit heap allocator over a pool of DESCRIPTORS free-region descriptors held in one
// RAM (start, units, next), free list sorted by address, spares on a second list. One
// request at a time. Init sweeps the whole RAM. Allocate walks the list and, when the carved
// region empties, unlinks it and moves its descriptor to the spares. Free walks the list,
// then coalesces with adjacent regions or splices in a spare descriptor. The walk is bounded
// at DESCRIPTORS visits, one RAM read each. A result waits in an output register; the next
// request is taken meanwhile.
// Depends on ffha_pkg and ffha_ram.
module first_fit_heap_allocator #(
	parameter int DESCRIPTORS = ffha_pkg::DESCRIPTORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ffha_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ffha_pkg::out_t                   out_data
);

	localparam int IW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
	localparam int SW = $clog2(DESCRIPTORS + 1);

	ffha_pkg::state_t state_q, state_d;

	logic [31:0] heap_start_q;
	logic [19:0] heap_size_q;
	logic [15:0] head_q, spare_q, free_total_q, min_free_q;
	logic        out_valid_q;
	ffha_pkg::out_t out_q;

	ffha_pkg::in_t  req_q;
	ffha_pkg::out_t res_q;
	ffha_pkg::desc_t ent_q, pent_q;
	logic [15:0] cur_q, prev_q, need_q, units_q;
	logic        prev_ok_q;
	logic [SW-1:0] steps_q;
	logic [IW-1:0] init_cnt_q;
	logic [35:0] prod_q;
	logic [31:0] hdr_q, end_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	ffha_pkg::desc_t ram_wdata, rd;

	ffha_ram #(
		.WIDTH($bits(ffha_pkg::desc_t)),
		.DEPTH(DESCRIPTORS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	function automatic logic ok_idx(input logic [15:0] i);
		return i < 16'(DESCRIPTORS);
	endfunction

	logic        is_alloc, walk_end, out_free;
	logic        fit, f_in, f_adj, f_below, nx_match;
	logic [31:0] a_new_start, r_end, in_hdr;
	logic [15:0] a_new_units, in_units, ft_after_alloc;
	logic [36:0] sum37;
	logic        need_big;
	logic [20:0] raw_sum;

	assign is_alloc       = (req_q.cmd == ffha_pkg::CMD_ALLOC);
	assign walk_end       = !ok_idx(cur_q) || (steps_q == SW'(DESCRIPTORS));
	assign out_free       = !out_valid_q || out_ready;
	assign fit            = rd.units >= need_q;
	assign a_new_start    = rd.start + {12'b0, need_q, 4'b0};
	assign a_new_units    = rd.units - need_q;
	assign ft_after_alloc = free_total_q - need_q;
	assign r_end          = rd.start + {12'b0, rd.units, 4'b0};
	assign f_in           = rd.start <= end_q;
	assign f_adj          = hdr_q == r_end;
	assign f_below        = end_q == rd.start;
	assign nx_match       = rd.start == end_q;
	assign sum37          = {1'b0, prod_q} + 37'(ffha_pkg::NEED_ROUND);
	assign need_big       = |sum37[36:20];
	assign raw_sum        = {1'b0, in_data.size} + 21'(ffha_pkg::NEED_ROUND);
	assign in_hdr         = in_data.address - 32'd4;
	assign in_units       = in_data.raw_mode ? raw_sum[19:4] : in_data.header_units;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (in_data.cmd)
						ffha_pkg::CMD_INIT:  state_d = ffha_pkg::ST_INIT;
						ffha_pkg::CMD_ALLOC: state_d = ffha_pkg::ST_A_MUL;
						ffha_pkg::CMD_FREE:  state_d = ffha_pkg::ST_WALK_RD;
						default:             state_d = ffha_pkg::ST_DONE;
					endcase
				end
			end
			ffha_pkg::ST_INIT: begin
				if (init_cnt_q == IW'(DESCRIPTORS - 1)) state_d = ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_A_MUL: state_d = ffha_pkg::ST_A_NEED;
			ffha_pkg::ST_A_NEED: begin
				state_d = need_big ? ffha_pkg::ST_DONE : ffha_pkg::ST_WALK_RD;
			end
			ffha_pkg::ST_WALK_RD: begin
				if (walk_end) state_d = is_alloc ? ffha_pkg::ST_DONE : ffha_pkg::ST_F_SP_RD;
				else state_d = ffha_pkg::ST_WALK_CHK;
			end
			ffha_pkg::ST_WALK_CHK: begin
				if (is_alloc) begin
					if (fit) state_d = (a_new_units == 16'd0) ? ffha_pkg::ST_A_UNLINK
						: ffha_pkg::ST_DONE;
					else state_d = ffha_pkg::ST_WALK_RD;
				end else if (!f_in) begin
					state_d = ffha_pkg::ST_F_SP_RD;
				end else if (f_adj) begin
					state_d = ok_idx(rd.next) ? ffha_pkg::ST_F_NX_RD : ffha_pkg::ST_DONE;
				end else if (f_below) begin
					state_d = ffha_pkg::ST_DONE;
				end else begin
					state_d = ffha_pkg::ST_WALK_RD;
				end
			end
			ffha_pkg::ST_A_UNLINK: state_d = ffha_pkg::ST_A_SPARE;
			ffha_pkg::ST_A_SPARE:  state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_F_NX_RD:  state_d = ffha_pkg::ST_F_NX_CHK;
			ffha_pkg::ST_F_NX_CHK: begin
				state_d = nx_match ? ffha_pkg::ST_F_NX_WR : ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_F_NX_WR: state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_F_SP_RD: begin
				state_d = ok_idx(spare_q) ? ffha_pkg::ST_F_SP_CHK : ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_F_SP_CHK: begin
				state_d = prev_ok_q ? ffha_pkg::ST_F_PREV_WR : ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_F_PREV_WR: state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_DONE: begin
				if (out_free) state_d = ffha_pkg::ST_IDLE;
			end
			default: state_d = ffha_pkg::ST_IDLE;
		endcase
	end

	// RAM control; all writes follow the reads they depend on, so no forwarding is needed
	always_comb begin
		in_ready  = (state_q == ffha_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = cur_q[IW-1:0];
		ram_raddr = cur_q[IW-1:0];
		ram_wdata = '0;
		unique case (state_q)
			ffha_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_cnt_q;
				if (init_cnt_q == '0)
					ram_wdata = '{start: heap_start_q, units: 16'(heap_size_q[19:4]),
						next: ffha_pkg::NIL};
				else if (init_cnt_q == IW'(DESCRIPTORS - 1))
					ram_wdata = '{start: 32'd0, units: 16'd0, next: ffha_pkg::NIL};
				else
					ram_wdata = '{start: 32'd0, units: 16'd0,
						next: 16'(init_cnt_q) + 16'd1};
			end
			ffha_pkg::ST_WALK_CHK: begin
				if (is_alloc) begin
					if (fit && a_new_units != 16'd0) begin
						ram_we    = 1'b1;
						ram_wdata = '{start: a_new_start, units: a_new_units, next: rd.next};
					end
				end else if (f_in && f_adj) begin
					ram_we    = 1'b1;
					ram_wdata = '{start: rd.start, units: rd.units + units_q, next: rd.next};
				end else if (f_in && f_below) begin
					ram_we    = 1'b1;
					ram_wdata = '{start: hdr_q, units: rd.units + units_q, next: rd.next};
				end
			end
			ffha_pkg::ST_A_UNLINK: begin
				ram_we    = prev_ok_q;
				ram_waddr = prev_q[IW-1:0];
				ram_wdata = '{start: pent_q.start, units: pent_q.units, next: ent_q.next};
			end
			ffha_pkg::ST_A_SPARE: begin
				ram_we    = 1'b1;
				ram_wdata = '{start: ent_q.start + {12'b0, need_q, 4'b0}, units: 16'd0,
					next: spare_q};
			end
			ffha_pkg::ST_F_NX_RD: ram_raddr = ent_q.next[IW-1:0];
			ffha_pkg::ST_F_NX_CHK: begin
				ram_we    = nx_match;
				ram_wdata = '{start: ent_q.start, units: ent_q.units + units_q + rd.units,
					next: rd.next};
			end
			ffha_pkg::ST_F_NX_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ent_q.next[IW-1:0];
				ram_wdata = '{start: pent_q.start, units: pent_q.units, next: spare_q};
			end
			ffha_pkg::ST_F_SP_RD: ram_raddr = spare_q[IW-1:0];
			ffha_pkg::ST_F_SP_CHK: begin
				ram_we    = 1'b1;
				ram_waddr = spare_q[IW-1:0];
				ram_wdata = '{start: hdr_q, units: units_q,
					next: prev_ok_q ? pent_q.next : head_q};
			end
			ffha_pkg::ST_F_PREV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = prev_q[IW-1:0];
				ram_wdata = '{start: pent_q.start, units: pent_q.units, next: cur_q};
			end
			default: ;
		endcase
	end

	// control and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffha_pkg::ST_IDLE;
			heap_start_q <= '0;
			heap_size_q  <= '0;
			head_q       <= ffha_pkg::NIL;
			spare_q      <= ffha_pkg::NIL;
			free_total_q <= '0;
			min_free_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ffha_pkg::REG_HEAP_START: heap_start_q <= cfg_wdata;
					ffha_pkg::REG_HEAP_SIZE:  heap_size_q  <= cfg_wdata[19:0];
					default: ;
				endcase
			end
			// a finished request reloads the output register in the same cycle
			if (out_valid_q && out_ready && state_q != ffha_pkg::ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				ffha_pkg::ST_INIT: begin
					if (init_cnt_q == IW'(DESCRIPTORS - 1)) begin
						head_q       <= 16'd0;
						spare_q      <= 16'd1;
						free_total_q <= 16'(heap_size_q[19:4]);
						min_free_q   <= 16'(heap_size_q[19:4]);
					end
				end
				ffha_pkg::ST_WALK_CHK: begin
					if (is_alloc) begin
						if (fit) begin
							free_total_q <= ft_after_alloc;
							if (ft_after_alloc < min_free_q) min_free_q <= ft_after_alloc;
						end
					end else if (f_in && (f_adj || f_below)) begin
						free_total_q <= free_total_q + units_q;
					end
				end
				ffha_pkg::ST_A_UNLINK: if (!prev_ok_q) head_q <= ent_q.next;
				ffha_pkg::ST_A_SPARE:  spare_q <= cur_q;
				ffha_pkg::ST_F_NX_WR:  spare_q <= ent_q.next;
				ffha_pkg::ST_F_SP_CHK: begin
					spare_q      <= rd.next;
					free_total_q <= free_total_q + units_q;
					if (!prev_ok_q) head_q <= spare_q;
				end
				ffha_pkg::ST_DONE: if (out_free) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// request payload and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (in_valid) begin
					req_q      <= in_data;
					res_q      <= '{result_address: 32'd0, success: 1'b0,
						header_write: (in_data.cmd == ffha_pkg::CMD_FREE),
						header_address: (in_data.cmd == ffha_pkg::CMD_FREE) ? in_hdr : 32'd0,
						header_value: 16'd0, free_units: 16'd0, low_water: 16'd0};
					cur_q      <= head_q;
					prev_ok_q  <= 1'b0;
					steps_q    <= '0;
					init_cnt_q <= '0;
					hdr_q      <= in_hdr;
					units_q    <= in_units;
					end_q      <= in_hdr + {12'b0, in_units, 4'b0};
				end
			end
			ffha_pkg::ST_INIT: begin
				init_cnt_q <= init_cnt_q + IW'(1);
				if (init_cnt_q == IW'(DESCRIPTORS - 1)) res_q.success <= 1'b1;
			end
			ffha_pkg::ST_A_MUL:  prod_q <= 36'(req_q.align) * 36'(req_q.size);
			ffha_pkg::ST_A_NEED: need_q <= sum37[19:4];
			ffha_pkg::ST_WALK_CHK: begin
				ent_q <= rd;
				if (is_alloc) begin
					if (fit) begin
						res_q.result_address <= rd.start + 32'd4;
						res_q.success        <= 1'b1;
						if (!req_q.raw_mode) begin
							res_q.header_write   <= 1'b1;
							res_q.header_address <= rd.start;
							res_q.header_value   <= need_q;
						end
					end else begin
						prev_q    <= cur_q;
						prev_ok_q <= 1'b1;
						pent_q    <= rd;
						cur_q     <= rd.next;
						steps_q   <= steps_q + SW'(1);
					end
				end else if (f_in) begin
					if (f_adj || f_below) begin
						res_q.success <= 1'b1;
					end else begin
						prev_q    <= cur_q;
						prev_ok_q <= 1'b1;
						pent_q    <= rd;
						cur_q     <= rd.next;
						steps_q   <= steps_q + SW'(1);
					end
				end
			end
			ffha_pkg::ST_F_NX_CHK: pent_q <= rd;
			ffha_pkg::ST_F_SP_CHK: begin
				cur_q         <= spare_q;
				res_q.success <= 1'b1;
			end
			ffha_pkg::ST_DONE: begin
				if (out_free) begin
					out_q <= '{result_address: res_q.result_address, success: res_q.success,
						header_write: res_q.header_write,
						header_address: res_q.header_address,
						header_value: res_q.header_value,
						free_units: free_total_q, low_water: min_free_q};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ffha_pkg::ST_IDLE))
		else $error("request accepted but sequencer stayed idle");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::ST_IDLE) |-> !ram_we)
		else $error("descriptor write while idle");
	a_init_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::ST_INIT && init_cnt_q != IW'(DESCRIPTORS - 1))
		|=> (state_q == ffha_pkg::ST_INIT))
		else $error("init sweep cut short");
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::ST_DONE && out_free) |=> out_valid_q)
		else $error("finished request not loaded into output register");
`endif

endmodule

### bench/testbench.sv
// Testbench for first_fit_heap_allocator: random and directed requests checked against
// an in-bench model of the first-fit free list, descriptor pool and unit counters.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 1ps

import ffha_pkg::*;

class heap_scoreboard;
	localparam int NDESC = DESCRIPTORS_DEF;
	logic [31:0] rstart [NDESC];
	logic [15:0] runits [NDESC];
	logic [15:0] rnext [NDESC];
	logic [15:0] free_head, spare_head, total, lowest;
	logic [31:0] base;
	logic [19:0] bytes;
	out_t expected_results [$];
	int errors;

	function new();
		free_head = NIL; spare_head = NIL; total = 0; lowest = 0;
		base = 0; bytes = 0; errors = 0;
		for (int i = 0; i < NDESC; i++) begin
			rstart[i] = 0; runits[i] = 0; rnext[i] = 0;
		end
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		if (idx == REG_HEAP_START) base = v;
		else bytes = v[19:0];
	endfunction

	function bit valid_idx(logic [15:0] i);
		return i < NDESC;
	endfunction

	function void push_spare(logic [15:0] d);
		rnext[d] = spare_head;
		spare_head = d;
	endfunction

	function void carve(in_t r, ref out_t o);
		logic [63:0] need64;
		logic [15:0] need, prev, cur;
		int steps;
		need64 = (64'(r.align) * 64'(r.size) + 64'd19) >> 4;
		if (need64 > 64'hFFFF) return;
		need = need64[15:0];
		prev = NIL; cur = free_head; steps = 0;
		while (valid_idx(cur) && steps < NDESC) begin
			steps++;
			if (runits[cur] >= need) begin
				o.result_address = rstart[cur] + 32'd4;
				o.success = 1;
				if (!r.raw_mode) begin
					o.header_write = 1;
					o.header_address = rstart[cur];
					o.header_value = need;
				end
				rstart[cur] = rstart[cur] + {need, 4'b0};
				runits[cur] = runits[cur] - need;
				total = total - need;
				if (total < lowest) lowest = total;
				if (runits[cur] == 0) begin
					if (valid_idx(prev)) rnext[prev] = rnext[cur];
					else free_head = rnext[cur];
					push_spare(cur);
				end
				return;
			end
			prev = cur;
			cur = rnext[cur];
		end
	endfunction

	function void release_block(in_t r, ref out_t o);
		logic [31:0] hdr, fend;
		logic [15:0] units, prev, cur, nx, nd;
		int steps;
		hdr = r.address - 32'd4;
		units = r.raw_mode ? 16'((32'(r.size) + 32'd19) >> 4) : r.header_units;
		fend = hdr + {12'b0, units, 4'b0};
		prev = NIL; cur = free_head; steps = 0;
		o.header_write = 1;
		o.header_address = hdr;
		while (valid_idx(cur) && steps < NDESC && rstart[cur] <= fend) begin
			steps++;
			if (hdr == rstart[cur] + {12'b0, runits[cur], 4'b0}) begin
				nx = rnext[cur];
				runits[cur] = runits[cur] + units;
				total = total + units;
				if (valid_idx(nx) && rstart[nx] == fend) begin
					runits[cur] = runits[cur] + runits[nx];
					rnext[cur] = rnext[nx];
					push_spare(nx);
				end
				o.success = 1;
				return;
			end
			prev = cur;
			if (fend == rstart[cur]) begin
				rstart[cur] = hdr;
				runits[cur] = runits[cur] + units;
				total = total + units;
				o.success = 1;
				return;
			end
			cur = rnext[cur];
		end
		nd = spare_head;
		if (!valid_idx(nd)) return;
		spare_head = rnext[nd];
		rstart[nd] = hdr;
		runits[nd] = units;
		total = total + units;
		if (valid_idx(prev)) begin
			rnext[nd] = rnext[prev];
			rnext[prev] = nd;
		end else begin
			rnext[nd] = free_head;
			free_head = nd;
		end
		o.success = 1;
	endfunction

	function void note_request(in_t r);
		out_t o;
		o = '0;
		case (r.cmd)
			CMD_INIT: begin
				rstart[0] = base;
				runits[0] = bytes[19:4];
				rnext[0] = NIL;
				for (int i = 1; i < NDESC - 1; i++) rnext[i] = 16'(i + 1);
				rnext[NDESC-1] = NIL;
				free_head = 0; spare_head = 1;
				total = bytes[19:4]; lowest = bytes[19:4];
				o.success = 1;
			end
			CMD_ALLOC: carve(r, o);
			CMD_FREE: release_block(r, o);
			default: ;
		endcase
		o.free_units = total;
		o.low_water = lowest;
		expected_results.push_back(o);
	endfunction

	function void check_result(out_t a);
		out_t e;
		if (expected_results.size() == 0) begin
			$error("result with nothing expected: %h", a);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (a.result_address !== e.result_address) begin
			$error("result_address exp %h got %h", e.result_address, a.result_address); errors++;
		end
		if (a.success !== e.success) begin
			$error("success exp %0d got %0d", e.success, a.success); errors++;
		end
		if (a.header_write !== e.header_write) begin
			$error("header_write exp %0d got %0d", e.header_write, a.header_write); errors++;
		end
		if (a.header_address !== e.header_address) begin
			$error("header_address exp %h got %h", e.header_address, a.header_address); errors++;
		end
		if (a.header_value !== e.header_value) begin
			$error("header_value exp %h got %h", e.header_value, a.header_value); errors++;
		end
		if (a.free_units !== e.free_units) begin
			$error("free_units exp %h got %h", e.free_units, a.free_units); errors++;
		end
		if (a.low_water !== e.low_water) begin
			$error("low_water exp %h got %h", e.low_water, a.low_water); errors++;
		end
	endfunction
endclass

module testbench;
	localparam int IN_W = $bits(in_t);

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;

	heap_scoreboard sb = new();
	bit send_gaps = 1, recv_gaps = 1, hold_off = 0;
	// live allocations, kept so frees mostly hand back real blocks
	logic [31:0] live_addr [$];
	logic [15:0] live_units [$];
	logic [31:0] cur_base;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off on demand
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				for (int i = 0; i < 400; i++) @(posedge clk);
				hold_off = 0;
				out_ready <= 1;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				out_ready <= 0;
				for (int i = 1; i < n; i++) @(posedge clk);
				@(posedge clk);
				out_ready <= 1;
			end else out_ready <= 1;
		end
	end

	// valid stays high after acceptance; an idle stretch or drain takes it down
	task automatic send(in_t r);
		int n;
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 7);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_data <= r;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
		// keep track of the headed blocks the model expects the block to hand out
		if (r.cmd == CMD_ALLOC && sb.expected_results[$].success && !r.raw_mode) begin
			live_addr.push_back(sb.expected_results[$].result_address);
			live_units.push_back(sb.expected_results[$].header_value);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	function automatic in_t mk(cmd_t c, logic [15:0] al, logic [19:0] sz, logic raw,
			logic [31:0] ad, logic [15:0] hu);
		in_t r;
		r.cmd = c; r.align = al; r.size = sz; r.raw_mode = raw;
		r.address = ad; r.header_units = hu;
		return r;
	endfunction

	task automatic setup_heap(logic [31:0] b, logic [19:0] sz);
		drain();
		write_cfg(REG_HEAP_START, b);
		write_cfg(REG_HEAP_SIZE, {12'b0, sz});
		cur_base = b;
		live_addr.delete(); live_units.delete();
		send(mk(CMD_INIT, 0, 0, 0, 0, 0));
	endtask

	task automatic random_request();
		in_t r;
		int k, pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.cmd = CMD_ALLOC;
			r.align = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
			r.size = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
			r.raw_mode = ($urandom_range(0, 7) == 0);
			r.address = $urandom; r.header_units = 16'($urandom);
		end else if (pick < 85 && live_addr.size() != 0) begin
			k = $urandom_range(0, live_addr.size() - 1);
			r.cmd = CMD_FREE;
			r.address = live_addr[k];
			r.header_units = live_units[k];
			r.align = 16'($urandom);
			if ($urandom_range(0, 5) == 0) begin
				r.raw_mode = 1;
				r.size = 20'(32'(live_units[k]) * 16 - 19);
			end else r.size = 20'($urandom);
			live_addr.delete(k); live_units.delete(k);
		end else if (pick < 95) begin
			// stray free: random address, often inside the heap
			r.cmd = CMD_FREE;
			r.address = ($urandom_range(0, 1)) ? cur_base + 4 + 16 * $urandom_range(0, 4000)
				: $urandom;
			r.header_units = ($urandom_range(0, 1)) ? 16'($urandom_range(1, 8)) : 16'($urandom);
			r.size = 20'($urandom); r.raw_mode = 1'($urandom); r.align = 16'($urandom);
		end else if (pick < 98) begin
			r = in_t'(IN_W'({$urandom, $urandom, $urandom}));
			r.cmd = CMD_NONE;
		end else begin
			r = in_t'(IN_W'({$urandom, $urandom, $urandom}));
			r.cmd = CMD_INIT;
			live_addr.delete(); live_units.delete();
		end
		send(r);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every command, special cases
		setup_heap(32'h0000_1000, 20'h1_0000);
		send(mk(CMD_ALLOC, 16'hFFFF, 20'hFFFFF, 0, 0, 0));   // need too large
		send(mk(CMD_ALLOC, 0, 0, 0, 0, 0));                  // zero bytes, one unit
		send(mk(CMD_ALLOC, 16, 4, 0, 0, 0));
		send(mk(CMD_ALLOC, 16, 4, 1, 0, 0));                 // raw, no header
		send(mk(CMD_ALLOC, 1, 20'd70000, 0, 0, 0));          // no region fits
		send(mk(CMD_FREE, 0, 0, 0, 32'h0000_1014, 16'd5));   // no free neighbour, splice in front
		send(mk(CMD_FREE, 0, 20'd61, 1, 32'h0000_1004, 0));  // raw free, spliced in after the first region
		send(mk(CMD_FREE, 0, 0, 0, 32'h0000_0104, 16'd2));   // splice in front
		send(mk(CMD_NONE, 16'hFFFF, 20'hFFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF));
		send(mk(CMD_FREE, 16'hFFFF, 20'hFFFFF, 1, 32'h0000_0000, 16'hFFFF)); // wrap
		setup_heap(32'hFFFF_FF00, 20'hFFFFF);                // wrapping heap, max size
		send(mk(CMD_ALLOC, 1, 20'd300, 0, 0, 0));
		send(mk(CMD_ALLOC, 16'hFFFF, 20'd15, 0, 0, 0));
		setup_heap(32'h0, 20'h0);                            // empty heap
		send(mk(CMD_ALLOC, 1, 1, 0, 0, 0));
		send(mk(CMD_FREE, 0, 0, 0, 32'h20, 16'd1));
		// exhaust spares with scattered frees
		setup_heap(32'h8000, 20'h0_1000);
		for (int i = 0; i < 130; i++)
			send(mk(CMD_FREE, 0, 0, 0, 32'h10_0004 + 32'(i) * 64, 16'd1));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: setup_heap($urandom, 20'h0_8000);
				1: setup_heap($urandom, 20'hFFFFF);
				2: setup_heap(32'hFFFF_FFF0, 20'h0_0800);
				default: setup_heap(32'h0, 20'h4_0000);
			endcase
			if (ph == 0) hold_off = 1;
			if (ph == 3) begin
				send_gaps = 0; recv_gaps = 0;
			end
			for (int i = 0; i < 110; i++) random_request();
		end
		drain();
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
